FILE: rtl/core/waypoint_autopilot_p_control_defines.svh
// Assertion shorthands for the autopilot checker.
// Each expects clk and rst in scope; rst holds the checks off.
`ifndef WAYPOINT_AUTOPILOT_P_CONTROL_DEFINES_SVH
`define WAYPOINT_AUTOPILOT_P_CONTROL_DEFINES_SVH

// same-cycle implication
`define WPAP_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WPAP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/wpap_pkg.sv
`timescale 1ns / 1ps
package wpap_pkg;

  localparam int MAX_WAYPOINTS  = 16;
  localparam int IDX_W          = 4;
  localparam int COUNT_W        = 5;
  localparam int GAIN_W         = 16;
  localparam int CLIMB_LIM_W    = 23;
  localparam int SPEED_W        = 23;
  localparam int VEL_W          = 24;
  localparam int CLIMB_W        = 24;
  localparam int THR_W          = 16;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 23;
  localparam int COORD_BITS_DEF = 24;
  localparam int ROOT_W         = 24;
  localparam int VSQ_W          = 2 * ROOT_W;
  localparam int AXIS_W         = 11;
  localparam int OUT_W          = 48;

  localparam int NEAR_XY_AXIS   = 1600;
  localparam int NEAR_XY_SQ     = 2560000;
  localparam int NEAR_Z         = 800;
  localparam int HALF_THROTTLE  = 32768;
  localparam int ALT_SHIFT      = 4;
  localparam int THR_SHIFT      = 8;

  localparam logic KIND_WRITE   = 1'b0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WP_COUNT,
    CFG_KP_ALT,
    CFG_KP_SPEED,
    CFG_MAX_CLIMB,
    CFG_MIN_THR,
    CFG_MAX_THR
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_NEAR,
    ST_DIST,
    ST_RD2,
    ST_TGT,
    ST_CLIMB,
    ST_SQRT,
    ST_THR,
    ST_CLAMP,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic sq_vx;
    logic mem_wr;
    logic clear_res;
    logic mem_rd;
    logic offsets;
    logic sq_vy;
    logic advance;
    logic sqrt_start;
    logic target;
    logic climb_mul;
    logic thr_mul;
    logic clamp;
    logic load_out;
  } wpap_cmd_t;

  typedef struct packed {
    logic is_write;
    logic skip;
    logic sqrt_busy;
  } wpap_sts_t;

endpackage

FILE: rtl/core/wpap_isqrt.sv
`timescale 1ns / 1ps
module wpap_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wpap_pkg::VSQ_W-1:0]    value,
  output logic                          busy,
  output logic [wpap_pkg::ROOT_W-1:0]   root
);
  import wpap_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int SH_W  = REM_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [VSQ_W-1:0] op;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [SH_W-1:0]  rem_sh;
  logic [SH_W-1:0]  trial;
  logic             fits;

  // one result bit per cycle, two operand bits brought down
  assign rem_sh = {rem, op[VSQ_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op   <= value;
      rem  <= '0;
      root <= '0;
      cnt  <= CNT_W'(ROOT_W - 1);
    end else if (busy) begin
      op   <= {op[VSQ_W-3:0], 2'b00};
      cnt  <= cnt - 1'b1;
      if (fits) begin
        rem  <= REM_W'(rem_sh - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/core/wpap_datapath.sv
`timescale 1ns / 1ps
module wpap_datapath #(
  parameter int COORD_BITS = wpap_pkg::COORD_BITS_DEF,
  parameter int IN_W       = 152
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wpap_pkg::wpap_cmd_t              cmd,
  output wpap_pkg::wpap_sts_t              sts,
  input  logic [IN_W-1:0]                  in_data,
  input  logic                             in_kind,
  input  logic                             cfg_we,
  input  logic [wpap_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [wpap_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [wpap_pkg::OUT_W-1:0]       out_data
);
  import wpap_pkg::*;

  localparam int C       = COORD_BITS;
  localparam int D_W     = C + 1;
  localparam int PA_W    = D_W + GAIN_W + 1;
  localparam int ERR_W   = ROOT_W + 1;
  localparam int PT_W    = ERR_W + GAIN_W + 1;
  localparam int ENTRY_W = 3 * C + SPEED_W;
  localparam int SQ_W    = 2 * AXIS_W;
  localparam int X_LO    = IDX_W;
  localparam int Y_LO    = X_LO + C;
  localparam int Z_LO    = Y_LO + C;
  localparam int VX_LO   = Z_LO + C;
  localparam int VY_LO   = VX_LO + VEL_W;
  localparam int SP_LO   = VY_LO + VEL_W;
  localparam int PAD_W   = OUT_W - (THR_W + CLIMB_W + IDX_W + 1);

  // captured item
  logic                      kind_q;
  logic [IDX_W-1:0]          slot_q;
  logic signed [C-1:0]       px_q, py_q, pz_q;
  logic signed [VEL_W-1:0]   vx_q, vy_q;
  logic [SPEED_W-1:0]        sp_q;

  // configuration and route progress
  logic [COUNT_W-1:0]        wp_count;
  logic [GAIN_W-1:0]         kp_alt, kp_speed;
  logic [CLIMB_LIM_W-1:0]    max_climb;
  logic [THR_W-1:0]          min_thr, max_thr;
  logic [IDX_W-1:0]          idx;
  logic                      finished;

  logic [ENTRY_W-1:0]        mem [MAX_WAYPOINTS];
  logic [ENTRY_W-1:0]        rd_q;

  logic [VSQ_W-1:0]          vx_sq, vy_sq, vsum_q;
  logic [AXIS_W-1:0]         adx_q, ady_q;
  logic                      ax_ok_q, ay_ok_q, z_ok_q;
  logic signed [D_W-1:0]     alt_diff_q;
  logic [SPEED_W-1:0]        tsp_q;
  logic signed [PA_W-1:0]    pa_q;
  logic signed [PT_W-1:0]    pt_q;
  logic [THR_W-1:0]          res_thr;
  logic [CLIMB_W-1:0]        res_climb;

  logic [ROOT_W-1:0]         root;
  logic                      sqrt_busy;

  logic [C-1:0]              wx, wy, wz;
  logic [SPEED_W-1:0]        wsp;
  logic signed [D_W-1:0]     dx, dy, dz;
  logic [D_W-1:0]            ax, ay, az;
  logic [SQ_W-1:0]           sqx, sqy;
  logic [SQ_W:0]             xy_sq;
  logic                      near;
  logic [COUNT_W-1:0]        idx_inc;
  logic [COUNT_W-1:0]        cnt_sat;
  logic [C-1:0]              t_alt;
  logic signed [ERR_W-1:0]   err;
  logic signed [PA_W-1:0]    climb_sh, lim, climb_c;
  logic signed [PT_W-1:0]    thr_v, thr_hi, thr_lo, thr_a, thr_b;

  wpap_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .value (vsum_q),
    .busy  (sqrt_busy),
    .root  (root)
  );

  assign sts.is_write  = kind_q == KIND_WRITE;
  assign sts.skip      = finished || (wp_count == '0);
  assign sts.sqrt_busy = sqrt_busy;

  assign wx  = rd_q[C-1:0];
  assign wy  = rd_q[2*C-1:C];
  assign wz  = rd_q[3*C-1:2*C];
  assign wsp = rd_q[ENTRY_W-1:3*C];

  always_comb begin
    dx = $signed({px_q[C-1], px_q}) - $signed({wx[C-1], wx});
    dy = $signed({py_q[C-1], py_q}) - $signed({wy[C-1], wy});
    dz = $signed({pz_q[C-1], pz_q}) - $signed({wz[C-1], wz});
    ax = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
    ay = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
    az = dz[D_W-1] ? D_W'(-dz) : D_W'(dz);
  end

  assign sqx     = adx_q * adx_q;
  assign sqy     = ady_q * ady_q;
  assign xy_sq   = {1'b0, sqx} + {1'b0, sqy};
  assign near    = ax_ok_q && ay_ok_q && z_ok_q && (xy_sq < (SQ_W + 1)'(NEAR_XY_SQ));
  assign idx_inc = {1'b0, idx} + 1'b1;
  assign cnt_sat = (cfg_wdata[COUNT_W-1:0] > COUNT_W'(MAX_WAYPOINTS)) ?
                   COUNT_W'(MAX_WAYPOINTS) : cfg_wdata[COUNT_W-1:0];
  assign t_alt   = finished ? '0 : wz;
  assign err     = $signed({2'b00, tsp_q}) - $signed({1'b0, root});

  // climb: floor shift, then symmetric clamp
  always_comb begin
    climb_sh = pa_q >>> ALT_SHIFT;
    lim      = $signed({{(PA_W - CLIMB_LIM_W){1'b0}}, max_climb});
    if (climb_sh > lim) begin
      climb_c = lim;
    end else if (climb_sh < -lim) begin
      climb_c = -lim;
    end else begin
      climb_c = climb_sh;
    end
  end

  // throttle: upper limit first, lower limit wins
  always_comb begin
    thr_v  = (pt_q >>> THR_SHIFT) + $signed(PT_W'(HALF_THROTTLE));
    thr_hi = $signed({{(PT_W - THR_W){1'b0}}, max_thr});
    thr_lo = $signed({{(PT_W - THR_W){1'b0}}, min_thr});
    thr_a  = (thr_v > thr_hi) ? thr_hi : thr_v;
    thr_b  = (thr_a < thr_lo) ? thr_lo : thr_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp_count  <= '0;
      kp_alt    <= GAIN_W'(256);
      kp_speed  <= GAIN_W'(655);
      max_climb <= CLIMB_LIM_W'(1280);
      min_thr   <= '0;
      max_thr   <= '1;
      idx       <= '0;
      finished  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          CFG_WP_COUNT: begin
            wp_count <= cnt_sat;
            idx      <= '0;
            finished <= cnt_sat == '0;
          end
          CFG_KP_ALT:    kp_alt    <= cfg_wdata[GAIN_W-1:0];
          CFG_KP_SPEED:  kp_speed  <= cfg_wdata[GAIN_W-1:0];
          CFG_MAX_CLIMB: max_climb <= cfg_wdata[CLIMB_LIM_W-1:0];
          CFG_MIN_THR:   min_thr   <= cfg_wdata[THR_W-1:0];
          CFG_MAX_THR:   max_thr   <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.advance && near) begin
        if (idx_inc < wp_count) begin
          idx <= idx_inc[IDX_W-1:0];
        end else begin
          finished <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[slot_q] <= {sp_q, pz_q, py_q, px_q};
    end
    if (cmd.mem_rd) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= in_kind;
      slot_q <= in_data[IDX_W-1:0];
      px_q   <= in_data[X_LO +: C];
      py_q   <= in_data[Y_LO +: C];
      pz_q   <= in_data[Z_LO +: C];
      vx_q   <= in_data[VX_LO +: VEL_W];
      vy_q   <= in_data[VY_LO +: VEL_W];
      sp_q   <= in_data[SP_LO +: SPEED_W];
    end
    // full-width square: operands sign-extend to the product width
    if (cmd.sq_vx) begin
      vx_sq <= vx_q * vx_q;
    end
    if (cmd.sq_vy) begin
      vy_sq <= vy_q * vy_q;
    end
    if (cmd.offsets) begin
      ax_ok_q <= ax < D_W'(NEAR_XY_AXIS);
      ay_ok_q <= ay < D_W'(NEAR_XY_AXIS);
      z_ok_q  <= az < D_W'(NEAR_Z);
      adx_q   <= ax[AXIS_W-1:0];
      ady_q   <= ay[AXIS_W-1:0];
    end
    if (cmd.advance) begin
      vsum_q <= vx_sq + vy_sq;
    end
    if (cmd.target) begin
      alt_diff_q <= $signed({t_alt[C-1], t_alt}) - $signed({pz_q[C-1], pz_q});
      tsp_q      <= finished ? '0 : wsp;
    end
    if (cmd.climb_mul) begin
      pa_q <= $signed({1'b0, kp_alt}) * alt_diff_q;
    end
    if (cmd.thr_mul) begin
      pt_q <= $signed({1'b0, kp_speed}) * err;
    end
    if (cmd.clear_res) begin
      res_thr   <= '0;
      res_climb <= '0;
    end else if (cmd.clamp) begin
      res_thr   <= thr_b[THR_W-1:0];
      res_climb <= climb_c[CLIMB_W-1:0];
    end
    if (cmd.load_out) begin
      out_data <= {{PAD_W{1'b0}}, sts.skip, idx, res_climb, res_thr};
    end
  end

endmodule

FILE: rtl/core/wpap_ctrl.sv
`timescale 1ns / 1ps
module wpap_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  wpap_pkg::wpap_sts_t  sts,
  output wpap_pkg::wpap_cmd_t  cmd
);
  import wpap_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_DISPATCH;
      ST_DISPATCH: state_next = (sts.is_write || sts.skip) ? ST_EMIT : ST_NEAR;
      ST_NEAR:     state_next = ST_DIST;
      ST_DIST:     state_next = ST_RD2;
      ST_RD2:      state_next = ST_TGT;
      ST_TGT:      state_next = ST_CLIMB;
      ST_CLIMB:    state_next = ST_SQRT;
      ST_SQRT:     if (!sts.sqrt_busy) state_next = ST_THR;
      ST_THR:      state_next = ST_CLAMP;
      ST_CLAMP:    state_next = ST_EMIT;
      ST_EMIT:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_DISPATCH: begin
        cmd.sq_vx = 1'b1;
        if (sts.is_write) begin
          cmd.mem_wr    = 1'b1;
          cmd.clear_res = 1'b1;
        end else if (sts.skip) begin
          cmd.clear_res = 1'b1;
        end else begin
          cmd.mem_rd = 1'b1;
        end
      end
      ST_NEAR: begin
        cmd.offsets = 1'b1;
        cmd.sq_vy   = 1'b1;
      end
      ST_DIST:  cmd.advance = 1'b1;
      ST_RD2: begin
        cmd.mem_rd     = 1'b1;
        cmd.sqrt_start = 1'b1;
      end
      ST_TGT:   cmd.target    = 1'b1;
      ST_CLIMB: cmd.climb_mul = 1'b1;
      ST_SQRT:  ;
      ST_THR:   cmd.thr_mul   = 1'b1;
      ST_CLAMP: cmd.clamp     = 1'b1;
      ST_EMIT:  cmd.load_out  = out_free;
      default:  ;
    endcase
  end

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/waypoint_autopilot_p_control.sv
`timescale 1ns / 1ps
// Waypoint-following autopilot. A waypoint write or a control step on a finished
// route passes through the DISPATCH and EMIT states before its result is registered;
// a control step that flies the route spends most of its time in the bit-serial
// square root that forms ground speed. One item is processed at a time: the next
// input transfer is taken once the previous result sits in the output register,
// even while that result still waits for the sink. Configuration writes land at
// once and are meant for an idle block; writing waypoint_count restarts the route.
module waypoint_autopilot_p_control #(
  parameter int  COORD_BITS = wpap_pkg::COORD_BITS_DEF,
  localparam int IN_BITS    = wpap_pkg::IDX_W + 3 * COORD_BITS + 2 * wpap_pkg::VEL_W
                              + wpap_pkg::SPEED_W,
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // slot, pos_x, pos_y, pos_z, vel_x, vel_y, wp_speed, zero fill
  input  logic [IN_W-1:0]                  s_tdata,
  // kind
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // throttle, climb_rate, active_index, done_res, zero fill
  output logic [wpap_pkg::OUT_W-1:0]       m_tdata,
  input  logic                             cfg_we,
  input  logic [wpap_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [wpap_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import wpap_pkg::*;

  wpap_cmd_t cmd;
  wpap_sts_t sts;

  wpap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wpap_datapath #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .in_kind   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_data  (m_tdata)
  );

endmodule

FILE: rtl/core/wpap_checker.sv
`timescale 1ns / 1ps
`include "waypoint_autopilot_p_control_defines.svh"
module wpap_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [wpap_pkg::OUT_W-1:0]  m_tdata
);
  import wpap_pkg::*;

  localparam logic [CLIMB_W-1:0] CLIMB_MOST_NEG = {1'b1, {(CLIMB_W - 1){1'b0}}};

  logic [CLIMB_W-1:0] out_climb;

  assign out_climb = m_tdata[THR_W +: CLIMB_W];

  `WPAP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
  `WPAP_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second transfer taken while busy")
  `WPAP_ASSERT_SAME(a_climb_sym, m_tvalid, out_climb != CLIMB_MOST_NEG, "climb clamp not symmetric")

endmodule

bind waypoint_autopilot_p_control wpap_checker u_wpap_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
